// ===== rtl/masked_byte_pattern_scan_top_assert.svh =====
// assertion macros for the pattern scan block
`ifndef MASKED_BYTE_PATTERN_SCAN_TOP_ASSERT_SVH
`define MASKED_BYTE_PATTERN_SCAN_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define MBPS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mbps same-cycle check failed");

// next-cycle implication, clocked on clk, off during reset
`define MBPS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mbps next-cycle check failed");

`endif

// ===== rtl/mbps_pkg.sv =====
`default_nettype none

package mbps_pkg;

	localparam int MAX_PATTERN_LEN_DEF = 32;
	localparam int OFFSET_BITS_DEF     = 32;
	localparam int PATTERN_REG_BYTES   = 32;
	localparam int PATTERN_WORD_W      = 64;
	localparam int PATTERN_WORDS       = PATTERN_REG_BYTES / (PATTERN_WORD_W / 8);
	localparam int LEN_W               = 6;
	localparam int CARE_W              = 32;
	localparam int ADDR_W              = 64;
	localparam int BYTE_W              = 8;
	localparam int CFG_DATA_W          = 64;
	localparam int CFG_IDX_W           = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LENGTH,
		REG_PATTERN_LO,
		REG_PATTERN_MID_LO,
		REG_PATTERN_MID_HI,
		REG_PATTERN_HI,
		REG_CARE_MASK,
		REG_BASE_ADDRESS
	} cfg_reg_t;

	// scan result handed to the output pipeline
	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] offset;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/mbps_if.sv =====
`default_nettype none

interface mbps_byte_if import mbps_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] image_byte;
	logic              last_byte;

	modport source (output valid, output image_byte, output last_byte, input ready);
	modport sink (input valid, input image_byte, input last_byte, output ready);
endinterface

interface mbps_result_if import mbps_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              found;
	logic [ADDR_W-1:0] match_address;

	modport source (output valid, output found, output match_address, input ready);
	modport sink (input valid, input found, input match_address, output ready);
endinterface

`default_nettype wire

// ===== rtl/mbps_cell.sv =====
`default_nettype none

module mbps_cell import mbps_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              clr,
	input  wire logic [BYTE_W-1:0] image_byte,
	input  wire logic [BYTE_W-1:0] pattern_byte,
	input  wire logic              care,
	input  wire logic              prev_flag,
	output logic                   hit,
	output logic                   flag_q
);

	// partial match through this pattern byte, ending at the current image byte
	assign hit = prev_flag & (~care | (image_byte == pattern_byte));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
		end else if (clr) begin
			flag_q <= 1'b0;
		end else if (en) begin
			flag_q <= hit;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/mbps_out_stage.sv =====
`default_nettype none

module mbps_out_stage import mbps_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire res_t              res,
	output logic                   can_push,
	input  wire logic [ADDR_W-1:0] base_address,
	mbps_result_if.source          result_out
);

	logic              v_s1;
	res_t              res_s1;
	logic              v_s2;
	logic              found_s2;
	logic [ADDR_W-1:0] addr_s2;
	logic              adv2;

	assign adv2     = ~v_s2 | result_out.ready;
	assign can_push = ~v_s1 | adv2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (can_push) begin
				v_s1 <= push;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (can_push && push) begin
			res_s1 <= res;
		end
		if (adv2 && v_s1) begin
			found_s2 <= res_s1.found;
			addr_s2  <= res_s1.found ? (base_address + res_s1.offset) : '0;
		end
	end

	assign result_out.valid         = v_s2;
	assign result_out.found         = found_s2;
	assign result_out.match_address = addr_s2;

endmodule

`default_nettype wire

// ===== rtl/masked_byte_pattern_scan_top.sv =====
// masked byte pattern scan
//
// byte_in takes one image byte per cycle (image_byte, last_byte) under
// valid/ready; result_out gives at most one word per image: found with the
// base address plus match offset, or found clear and address zero when the
// last byte passes with no match. cfg_we/cfg_index/cfg_data write the pattern
// registers, which the user must do only with no result pending; not enforced.
// throughput: one byte per cycle; the compare runs in a row of cells, one per
// pattern byte, each passing its partial-match flag to the next cell.
// the result for an accepted byte is held in the scan/offset stage, then
// registered with the base address added, and that stage drives result_out.
// reset clears the registers, the scan state and both output stages.
// when the receiver stalls, the output word holds and one more result can wait
// in the first stage; byte_in.ready drops while both stages are full and the
// receiver stalls, for every byte, whether or not it would cause a result.
`default_nettype none

module masked_byte_pattern_scan_top import mbps_pkg::*; #(
	parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF,
	parameter int OFFSET_BITS     = OFFSET_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	mbps_byte_if.sink                  byte_in,
	mbps_result_if.source              result_out
);

	localparam int NCELL = (MAX_PATTERN_LEN < PATTERN_REG_BYTES) ?
		MAX_PATTERN_LEN : PATTERN_REG_BYTES;
	localparam int IDX_W = (NCELL > 1) ? $clog2(NCELL) : 1;

	logic [LEN_W-1:0]          pattern_length_q;
	logic [PATTERN_WORD_W-1:0] pattern_q [PATTERN_WORDS];
	logic [CARE_W-1:0]         care_q;
	logic [ADDR_W-1:0]         base_q;

	logic [OFFSET_BITS-1:0] seen_q;
	logic                   matched_q;

	logic                   accept;
	logic [LEN_W-1:0]       len_use;
	logic [LEN_W-1:0]       len_m1;
	logic                   len_zero;
	logic [OFFSET_BITS-1:0] len_ext;
	logic [OFFSET_BITS-1:0] len_m1_ext;
	logic                   seen_max;
	logic [OFFSET_BITS-1:0] seen_next;
	logic [OFFSET_BITS-1:0] offset;
	logic [NCELL-1:0]       hit_vec;
	logic [NCELL-1:0]       flag_vec;
	logic                   hit;
	logic                   cell_en;
	logic                   cell_clr;
	logic                   res_push;
	logic                   can_push;
	res_t                   res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= '0;
			for (int w = 0; w < PATTERN_WORDS; w++) begin
				pattern_q[w] <= '0;
			end
			care_q <= '0;
			base_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[LEN_W-1:0];
				REG_PATTERN_LO:     pattern_q[0] <= cfg_data;
				REG_PATTERN_MID_LO: pattern_q[1] <= cfg_data;
				REG_PATTERN_MID_HI: pattern_q[2] <= cfg_data;
				REG_PATTERN_HI:     pattern_q[3] <= cfg_data;
				REG_CARE_MASK:      care_q <= cfg_data[CARE_W-1:0];
				REG_BASE_ADDRESS:   base_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign len_use    = (pattern_length_q > LEN_W'(NCELL)) ? LEN_W'(NCELL) : pattern_length_q;
	assign len_zero   = (len_use == '0);
	assign len_m1     = len_use - 1'b1;
	assign len_ext    = OFFSET_BITS'(len_use);
	assign len_m1_ext = OFFSET_BITS'(len_m1);

	assign accept   = byte_in.valid & byte_in.ready;
	assign cell_en  = accept & ~matched_q & ~byte_in.last_byte;
	assign cell_clr = accept & byte_in.last_byte;

	// row of compare cells, cell i holds the match state through pattern byte i
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		mbps_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.en          (cell_en),
			.clr         (cell_clr),
			.image_byte  (byte_in.image_byte),
			.pattern_byte(pattern_q[i / 8][(i % 8) * 8 +: 8]),
			.care        (care_q[i]),
			.prev_flag   ((i == 0) ? 1'b1 : flag_vec[(i == 0) ? 0 : i - 1]),
			.hit         (hit_vec[i]),
			.flag_q      (flag_vec[i])
		);
	end

	assign hit = len_zero ? (seen_q == '0) : hit_vec[len_m1[IDX_W-1:0]];

	assign seen_max  = &seen_q;
	assign seen_next = seen_max ? seen_q : seen_q + 1'b1;
	assign offset    = len_zero ? '0 : (seen_max ? seen_q - len_ext : seen_q - len_m1_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= '0;
			matched_q <= 1'b0;
		end else if (accept) begin
			if (byte_in.last_byte) begin
				seen_q    <= '0;
				matched_q <= 1'b0;
			end else if (!matched_q) begin
				seen_q <= seen_next;
				if (hit) begin
					matched_q <= 1'b1;
				end
			end
		end
	end

	assign res_push   = accept & ~matched_q & (hit | byte_in.last_byte);
	assign res.found  = hit;
	assign res.offset = hit ? ADDR_W'(offset) : '0;

	assign byte_in.ready = can_push;

	mbps_out_stage u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (res_push),
		.res         (res),
		.can_push    (can_push),
		.base_address(base_q),
		.result_out  (result_out)
	);

`include "masked_byte_pattern_scan_top_assert.svh"

	`MBPS_ASSERT_SAME(a_miss_zero_addr, result_out.valid && !result_out.found, result_out.match_address == '0)
	`MBPS_ASSERT_SAME(a_one_result, accept && matched_q, !res_push)
	`MBPS_ASSERT_NEXT(a_last_clears, accept && byte_in.last_byte, (seen_q == '0) && !matched_q && (flag_vec == '0))
	`MBPS_ASSERT_NEXT(a_seen_step, accept && !byte_in.last_byte && !matched_q && !seen_max, seen_q == $past(seen_q) + 1'b1)

endmodule

`default_nettype wire
